/* hw/rtl/sh24_pkg.sv */
package sh24_pkg;

    // SipHash initialisation constants.
    localparam logic [63:0] SIP_C0 = 64'h736f_6d65_7073_6575;
    localparam logic [63:0] SIP_C1 = 64'h646f_7261_6e64_6f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c79_6765_6e65_7261;
    localparam logic [63:0] SIP_C3 = 64'h7465_6462_7974_6573;

    localparam logic [63:0] FINAL_MARK     = 64'h0000_0000_0000_00ff;
    localparam logic [2:0]  LAST_WORD_BYTE = 3'd7;

    // Round numbers inside one job: the message is folded in after the
    // second compression round, and finalisation ends after the sixth.
    localparam logic [2:0]  RND_FOLD = 3'd1;
    localparam logic [2:0]  RND_LAST = 3'd5;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Configuration register indexes.
    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    typedef enum logic [1:0] {
        CMD_ABSORB = 2'd0,
        CMD_FINISH = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        OP_WORD   = 2'd0,
        OP_FINAL  = 2'd1,
        OP_REPEAT = 2'd2,
        OP_CLEAR  = 2'd3
    } op_code_t;

    typedef struct packed {
        op_code_t    code;
        logic [63:0] word;
    } op_t;

    typedef struct packed {
        logic push;
        op_t  op;
    } q_push_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_OUT
    } back_state_t;

    typedef logic [3:0][63:0] lanes_t;

    function automatic lanes_t restart_lanes(input logic [63:0] k0, input logic [63:0] k1);
        lanes_t v;
        v[0] = k0 ^ SIP_C0;
        v[1] = k1 ^ SIP_C1;
        v[2] = k0 ^ SIP_C2;
        v[3] = k1 ^ SIP_C3;
        return v;
    endfunction

    function automatic lanes_t sip_round(input lanes_t v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        lanes_t      r;
        a = v[0];
        b = v[1];
        c = v[2];
        d = v[3];
        a = a + b;
        c = c + d;
        b = {b[50:0], b[63:51]};
        d = {d[47:0], d[63:48]};
        b = b ^ a;
        d = d ^ c;
        a = {a[31:0], a[63:32]};
        c = c + b;
        a = a + d;
        b = {b[46:0], b[63:47]};
        d = {d[42:0], d[63:43]};
        b = b ^ c;
        d = d ^ a;
        c = {c[31:0], c[63:32]};
        r[0] = a;
        r[1] = b;
        r[2] = c;
        r[3] = d;
        return r;
    endfunction

endpackage

/* hw/rtl/siphash_2_4_stream.sv */
// Keyed SipHash-2-4 over a byte stream, 64-bit result.
// Input channel (s_valid/s_ready): one item carries a command and a byte.
// Absorb adds the byte, finish emits the hash of all bytes since the last
// clear or reset, clear restarts the lanes from the two key registers.
// Result channel (m_valid/m_ready): one item per finish command.
// Configuration: cfg_wr_en writes cfg_data into key_low (index 0) or
// key_high (index 1) at the clock edge; new keys take effect at the next
// clear. Write the keys only while the block is idle.
// Throughput: one input item per cycle while s_ready is high. Each eighth
// byte costs the round engine a load and two rounds, so a full byte stream
// never stalls the input. A finish occupies the round engine for a load,
// six rounds and the output step, during which the command queue absorbs
// up to its depth in further items before s_ready falls.
// Result path: a first finish passes the queue, a load, six rounds and the
// output register; a repeated finish is answered from the held hash.
// Reset (aresetn low, synchronous) clears keys to zero, the lanes to their
// zero-key values, the queue and the held hash. When the receiver stalls,
// the result waits in the output register; the engine then holds its next
// result and the queue fills, after which s_ready goes low.
module siphash_2_4_stream
    import sh24_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    q_push_t     q_push;
    logic        q_full;
    logic        q_valid;
    op_t         q_head;
    logic        q_pop;

    // Key registers. The lanes only read them when a clear is carried out.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front packs bytes into words, tracks the length and the finished
    // state, and turns each item into at most one job for the round engine.
    sh24_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_data_byte (s_data_byte),
        .q_full      (q_full),
        .q_push      (q_push)
    );

    // Jobs wait here in order, so the front keeps taking bytes while the
    // engine is busy with rounds.
    sh24_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    // The back runs one SipRound per cycle and owns the output register.
    sh24_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .key_low      (key_low_reg),
        .key_high     (key_high_reg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule

/* hw/rtl/sh24_front.sv */
module sh24_front
    import sh24_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_data_byte,
    input  logic        q_full,
    output q_push_t     q_push
);

    logic [55:0] partial_reg;
    logic [55:0] partial_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [7:0]  length_reg;
    logic [7:0]  length_next;
    logic        done_reg;
    logic        done_next;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        partial_next = partial_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        done_next    = done_reg;
        q_push.push    = 1'b0;
        q_push.op.code = OP_WORD;
        q_push.op.word = '0;
        if (accept) begin
            case (s_command)
                CMD_ABSORB: begin
                    if (!done_reg) begin
                        length_next = length_reg + 8'd1;
                        if (count_reg == LAST_WORD_BYTE) begin
                            q_push.push    = 1'b1;
                            q_push.op.code = OP_WORD;
                            q_push.op.word = {s_data_byte, partial_reg};
                            partial_next   = '0;
                            count_next     = '0;
                        end else begin
                            partial_next[{count_reg, 3'b000} +: 8] = s_data_byte;
                            count_next = count_reg + 3'd1;
                        end
                    end
                end
                CMD_FINISH: begin
                    q_push.push = 1'b1;
                    if (!done_reg) begin
                        q_push.op.code = OP_FINAL;
                        q_push.op.word = {length_reg, partial_reg};
                        done_next      = 1'b1;
                    end else begin
                        q_push.op.code = OP_REPEAT;
                    end
                end
                CMD_CLEAR: begin
                    q_push.push    = 1'b1;
                    q_push.op.code = OP_CLEAR;
                    partial_next   = '0;
                    count_next     = '0;
                    length_next    = '0;
                    done_next      = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            count_reg   <= '0;
            length_reg  <= '0;
            done_reg    <= 1'b0;
        end else begin
            partial_reg <= partial_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            done_reg    <= done_next;
        end
    end

endmodule

/* hw/rtl/sh24_queue.sv */
module sh24_queue
    import sh24_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  q_push_t q_push,
    output logic    q_full,
    output logic    q_valid,
    output op_t     q_head,
    input  logic    q_pop
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    op_t              entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_head  = entries_reg[rd_ptr_reg];
    assign do_push = q_push.push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= q_push.op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The fill count never passes the depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    // Pointers meet whenever the queue is empty or full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers inconsistent with fill count");

endmodule

/* hw/rtl/sh24_back.sv */
module sh24_back
    import sh24_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] key_low,
    input  logic [63:0] key_high,
    input  logic        q_valid,
    input  op_t         q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value
);

    back_state_t state_reg;
    back_state_t state_next;
    lanes_t      lanes_reg;
    lanes_t      lanes_next;
    lanes_t      rounded;
    logic [63:0] word_reg;
    logic [63:0] word_next;
    logic        final_reg;
    logic        final_next;
    logic [2:0]  rnd_reg;
    logic [2:0]  rnd_next;
    logic [63:0] held_reg;
    logic [63:0] held_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [63:0] m_hash_reg;
    logic [63:0] m_hash_next;
    logic        out_free;
    logic        out_load;
    logic [63:0] lane_xor;

    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;
    assign rounded      = sip_round(lanes_reg);
    assign lane_xor     = lanes_reg[0] ^ lanes_reg[1] ^ lanes_reg[2] ^ lanes_reg[3];

    always_comb begin
        state_next  = state_reg;
        lanes_next  = lanes_reg;
        word_next   = word_reg;
        final_next  = final_reg;
        rnd_next    = rnd_reg;
        held_next   = held_reg;
        m_hash_next = m_hash_reg;
        out_load    = 1'b0;
        q_pop       = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    case (q_head.code)
                        OP_CLEAR: begin
                            q_pop      = 1'b1;
                            lanes_next = restart_lanes(key_low, key_high);
                        end
                        OP_WORD, OP_FINAL: begin
                            q_pop         = 1'b1;
                            lanes_next[3] = lanes_reg[3] ^ q_head.word;
                            word_next     = q_head.word;
                            final_next    = (q_head.code == OP_FINAL);
                            rnd_next      = '0;
                            state_next    = BK_ROUND;
                        end
                        OP_REPEAT: begin
                            if (out_free) begin
                                q_pop       = 1'b1;
                                out_load    = 1'b1;
                                m_hash_next = held_reg;
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_ROUND: begin
                lanes_next = rounded;
                rnd_next   = rnd_reg + 3'd1;
                if (rnd_reg == RND_FOLD) begin
                    lanes_next[0] = rounded[0] ^ word_reg;
                    if (final_reg) begin
                        lanes_next[2] = rounded[2] ^ FINAL_MARK;
                    end else begin
                        state_next = BK_IDLE;
                    end
                end
                if (rnd_reg == RND_LAST) begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    m_hash_next = lane_xor;
                    held_next   = lane_xor;
                    state_next  = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            lanes_reg   <= restart_lanes('0, '0);
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
            rnd_reg     <= '0;
            final_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lanes_reg   <= lanes_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
            rnd_reg     <= rnd_next;
            final_reg   <= final_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        m_hash_reg <= m_hash_next;
    end

    // A word job never runs past its two compression rounds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_ROUND && !final_reg) |-> (rnd_reg <= RND_FOLD))
        else $error("word job ran too many rounds");

    // A result is only loaded when the output register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded over an untaken one");

    // The queue is only drained while the round unit is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == BK_IDLE && q_valid))
        else $error("queue popped while busy or empty");

endmodule

/* sim/siphash_checker.sv */
`timescale 1ns / 100ps

module siphash_checker
    import sh24_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_hash_value,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    output int unsigned fail_count,
    output int unsigned waiting
);

    typedef logic [3:0][63:0] lane_set_t;

    logic [63:0] key_lo;
    logic [63:0] key_hi;
    lane_set_t   lanes;
    logic [55:0] tail_bytes;
    logic [2:0]  tail_fill;
    logic [7:0]  msg_len;
    logic        sealed;
    logic [63:0] held_hash;
    logic [63:0] hash_q [$];
    logic [63:0] want;
    int unsigned errors = 0;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned n);
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic lane_set_t sip_mix(input lane_set_t v);
        lane_set_t r;
        r    = v;
        r[0] = r[0] + r[1];
        r[2] = r[2] + r[3];
        r[1] = rotl64(r[1], 13) ^ r[0];
        r[3] = rotl64(r[3], 16) ^ r[2];
        r[0] = rotl64(r[0], 32);
        r[2] = r[2] + r[1];
        r[0] = r[0] + r[3];
        r[1] = rotl64(r[1], 17) ^ r[2];
        r[3] = rotl64(r[3], 21) ^ r[0];
        r[2] = rotl64(r[2], 32);
        return r;
    endfunction

    function automatic void rekey();
        lanes[0]   = key_lo ^ SIP_C0;
        lanes[1]   = key_hi ^ SIP_C1;
        lanes[2]   = key_lo ^ SIP_C2;
        lanes[3]   = key_hi ^ SIP_C3;
        tail_bytes = '0;
        tail_fill  = '0;
        msg_len    = '0;
        sealed     = 1'b0;
    endfunction

    function automatic void fold_word(input logic [63:0] m);
        lanes[3] = lanes[3] ^ m;
        lanes    = sip_mix(sip_mix(lanes));
        lanes[0] = lanes[0] ^ m;
    endfunction

    function automatic void take_item(input logic [1:0] cmd, input logic [7:0] b);
        case (cmd)
            CMD_ABSORB: begin
                // Bytes after a finish are dropped until the next clear.
                if (!sealed) begin
                    msg_len = msg_len + 8'd1;
                    if (tail_fill == LAST_WORD_BYTE) begin
                        fold_word({b, tail_bytes});
                        tail_bytes = '0;
                        tail_fill  = '0;
                    end else begin
                        tail_bytes = tail_bytes | (56'(b) << (8 * tail_fill));
                        tail_fill  = tail_fill + 3'd1;
                    end
                end
            end
            CMD_FINISH: begin
                if (!sealed) begin
                    fold_word({msg_len, tail_bytes});
                    lanes[2] = lanes[2] ^ FINAL_MARK;
                    repeat (4) lanes = sip_mix(lanes);
                    held_hash = lanes[0] ^ lanes[1] ^ lanes[2] ^ lanes[3];
                    sealed    = 1'b1;
                end
                hash_q.push_back(held_hash);
            end
            CMD_CLEAR: begin
                rekey();
            end
            default: begin
                // The spare command code leaves everything as it was.
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            key_lo    = '0;
            key_hi    = '0;
            held_hash = '0;
            rekey();
            hash_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_KEY_LOW) begin
                    key_lo = cfg_data;
                end else begin
                    key_hi = cfg_data;
                end
            end
            if (m_valid && m_ready) begin
                if (hash_q.size() == 0) begin
                    $display("%0t: unexpected hash, expected none, actual %h",
                             $time, m_hash_value);
                    errors++;
                end else begin
                    want = hash_q.pop_front();
                    if (m_hash_value !== want) begin
                        $display("%0t: hash_value mismatch, expected %h, actual %h",
                                 $time, want, m_hash_value);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                take_item(s_command, s_data_byte);
            end
        end
        fail_count <= errors;
        waiting    <= hash_q.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench
    import sh24_pkg::*;
();

    // Generous bound on the whole run; the slowest legal run stays far below it.
    localparam int unsigned CYCLE_LIMIT   = 500000;
    // Quiet time that lets queued absorb and clear items leave the block.
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned PHASE_ITEMS   = 200;
    // The one command code that the block has no meaning for.
    localparam logic [1:0]  CMD_SPARE     = 2'd3;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command   = CMD_ABSORB;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [63:0] m_hash_value;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_index   = CFG_KEY_LOW;
    logic [63:0] cfg_data    = 64'h0;

    int unsigned fail_count;
    int unsigned waiting;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    bit          gaps_on     = 1'b0;
    int unsigned rx_mode     = 0;
    int unsigned rx_hold     = 0;
    bit          rx_level    = 1'b1;
    bit          sealed      = 1'b0;
    int unsigned counted     = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    siphash_2_4_stream i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    siphash_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .waiting      (waiting)
    );

    // The receiver has three behaviours: always ready, a coin toss every
    // cycle, and long alternating runs of ready and stall. The long stalls
    // back the result up into the block until its queue fills and s_ready
    // falls, which the other two modes rarely reach.
    always @(posedge aclk) begin
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 1) == 1);
            end
            default: begin
                if (rx_hold == 0) begin
                    rx_level = !rx_level;
                    rx_hold  = $urandom_range(1, 20);
                end
                rx_hold--;
                m_ready <= rx_level;
            end
        endcase
    end

    // Watchdog: a hung handshake or a hash that never arrives ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL siphash_2_4_stream");
            $finish;
        end
    end

    // Presents one item and returns at the clock edge that accepts it. The
    // sender works in bursts: when a burst is used up it may drop valid for
    // a random gap before the next one starts. Valid is only ever lowered in
    // the step right after an acceptance and raised again at a later edge.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_data_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // Items the block simply drops do not count towards a phase.
        if (!(cmd == CMD_SPARE || (cmd == CMD_ABSORB && sealed))) begin
            counted++;
        end
        if (cmd == CMD_FINISH) begin
            sealed = 1'b1;
        end else if (cmd == CMD_CLEAR) begin
            sealed = 1'b0;
        end
    endtask

    // Drops valid, waits for every outstanding hash, then leaves the block
    // alone long enough for any queued absorb or clear to be worked off, so
    // that a key written afterwards cannot reach a clear that is still queued.
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_keys(input logic [63:0] lo, input logic [63:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_KEY_LOW;
        cfg_data  <= lo;
        @(posedge aclk);
        cfg_index <= CFG_KEY_HIGH;
        cfg_data  <= hi;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly short messages, so that many hashes come out; a few cross the
    // length wrap at 256 bytes.
    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            return $urandom_range(0, 20);
        end
        if (roll < 97) begin
            return $urandom_range(21, 48);
        end
        return $urandom_range(250, 300);
    endfunction

    // One well-formed message with random content: usually opened by a
    // clear, closed by a finish, sometimes followed by a repeated finish or
    // a stray byte after the finish. Now and then a spare command or a clear
    // breaks into the middle of the bytes.
    task automatic send_message(input bit lead_clear, input int unsigned len);
        if (lead_clear) begin
            send_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
        end
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 4) begin
                send_item($urandom_range(0, 1) ? CMD_SPARE : CMD_CLEAR,
                          8'($urandom_range(0, 255)));
            end
            send_item(CMD_ABSORB, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 88) begin
            send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0) begin
                send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 5) == 0) begin
                send_item(CMD_ABSORB, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        bit          lead;
        int unsigned len;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset keys of zero: the hash of the empty
        // message, its repeat, a byte after the finish that must be dropped,
        // the spare command, then a clear and a two byte message at the byte
        // extremes.
        send_item(CMD_FINISH, 8'h00);
        send_item(CMD_FINISH, 8'hff);
        send_item(CMD_ABSORB, 8'hff);
        send_item(CMD_SPARE, 8'hff);
        send_item(CMD_CLEAR, 8'h00);
        send_item(CMD_ABSORB, 8'hff);
        send_item(CMD_ABSORB, 8'h00);
        send_item(CMD_FINISH, 8'h00);
        settle();

        // The usual counting key and a fifteen byte message, which fills one
        // whole word and leaves a seven byte tail for the finish.
        write_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
        send_item(CMD_CLEAR, 8'h00);
        for (int unsigned b = 0; b < 15; b++) begin
            send_item(CMD_ABSORB, 8'(b));
        end
        send_item(CMD_FINISH, 8'h00);
        settle();

        // Random phases, each with its own keys, sender gaps and receiver
        // behaviour. The first phase runs with no idling on either side.
        for (int unsigned phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    key_lo = '1;
                    key_hi = '1;
                end
                1: begin
                    key_lo = '0;
                    key_hi = '1;
                end
                3: begin
                    key_lo = '1;
                    key_hi = '0;
                end
                default: begin
                    key_lo = {$urandom, $urandom};
                    key_hi = {$urandom, $urandom};
                end
            endcase
            write_keys(key_lo, key_hi);
            gaps_on = (phase != 0);
            rx_mode = phase % 3;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                // The first message of phase three carries on from the
                // bytes left at the end of phase two, so its lanes still
                // hold the old key although the new one has been written.
                lead = ($urandom_range(0, 9) != 0) && !(phase == 3 && counted == 0);
                if (phase == 1 && counted == 0) begin
                    len = $urandom_range(256, 300);
                end else begin
                    len = pick_length();
                end
                send_message(lead, len);
            end
            if (phase == 2) begin
                send_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
                repeat (5) send_item(CMD_ABSORB, 8'($urandom_range(0, 255)));
            end
            settle();
        end

        if (fail_count == 0 && waiting == 0) begin
            $display("PASS siphash_2_4_stream");
        end else begin
            $display("FAIL siphash_2_4_stream");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/sh24_pkg.sv
hw/rtl/sh24_front.sv
hw/rtl/sh24_queue.sv
hw/rtl/sh24_back.sv
hw/rtl/siphash_2_4_stream.sv
sim/siphash_checker.sv
sim/testbench.sv
